// ===== src/assert_macros.svh =====
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is high
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ftpad_pkg.sv =====
// types and constants for the ftp ascii receive decoder
`timescale 1ns / 1ps

package ftpad_pkg;

  localparam logic [7:0] BYTE_ESC = 8'hFF;
  localparam logic [7:0] BYTE_EOR = 8'h01;
  localparam logic [7:0] BYTE_EOF = 8'h02;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  // configuration register indexes
  localparam logic CFG_ASCII_MODE       = 1'b0;
  localparam logic CFG_RECORD_STRUCTURE = 1'b1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // one decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       kind;
  } result_t;

endpackage

// ===== src/ftp_ascii_receive_decoder.sv =====
// ftp ascii receive decoder: network-form bytes in, local text bytes out
`timescale 1ns / 1ps
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: data_byte, tuser: start_req
//  m_axis    out  m_axis_tvalid/tready      tdata: out_byte, tuser: kind, tlast: last
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data (always ready)
//
//  one request is decoded in the cycle it is accepted; its zero to three results
//  land in a three-slot result register and leave one per cycle while m_axis_tready is high.
//  a request giving one result sustains one request per clock while the output is not
//  stalled; a request giving n results holds the input, set by the single output port.
//  a new request is taken while the last result of the previous one leaves.
//  rst (synchronous) empties the result register, clears the held cr, held esc
//  and finished flags, and sets ascii_mode=1, record_structure=0.

module ftp_ascii_receive_decoder
  import ftpad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0] s_axis_tuser,   // [0] start_req
  // decoded byte stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [0:0] m_axis_tuser,   // [0] kind
  output logic       m_axis_tlast,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [0:0] cfg_data
);

  // configuration registers
  logic ascii_mode;
  logic record_structure;

  // decoder flags
  logic cr_pending;
  logic esc_pending;
  logic finished;

  // result register: slot 0 is the head, cnt results remain
  result_t     slot [3];
  logic [1:0]  cnt;

  // decode outputs
  result_t     grp_next [3];
  logic [1:0]  n_next;
  logic        cr_next;
  logic        esc_next;
  logic        fin_next;

  logic s_accept;
  logic m_accept;
  logic [7:0] c;

  assign c         = s_axis_tdata;
  assign cfg_ready = 1'b1;

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = slot[0].data;
  assign m_axis_tuser  = slot[0].kind;
  assign m_axis_tlast  = (cnt == 2'd1);

  // free when empty, or when the only result left goes out this cycle
  assign s_axis_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  // decode one byte against the flags; results are appended in emit order
  always_comb begin
    grp_next[0] = '{data: BYTE_NUL, kind: KIND_DATA};
    grp_next[1] = '{data: BYTE_NUL, kind: KIND_DATA};
    grp_next[2] = '{data: BYTE_NUL, kind: KIND_DATA};
    n_next      = 2'd0;
    // start of a new transfer clears every flag before the byte counts
    cr_next     = s_axis_tuser[0] ? 1'b0 : cr_pending;
    esc_next    = s_axis_tuser[0] ? 1'b0 : esc_pending;
    fin_next    = s_axis_tuser[0] ? 1'b0 : finished;

    if (fin_next) begin
      // end marker seen: drop everything until the next start
      n_next = 2'd0;
    end else if (!ascii_mode) begin
      // image mode: straight through, flags untouched
      grp_next[0] = '{data: c, kind: KIND_DATA};
      n_next      = 2'd1;
    end else begin
      case (c)
        BYTE_CR: begin
          if (esc_next) begin
            grp_next[n_next] = '{data: BYTE_ESC, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
            esc_next         = 1'b0;
          end
          // cr after cr: release the older one, hold the new one
          if (cr_next) begin
            grp_next[n_next] = '{data: BYTE_CR, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
          end
          cr_next = 1'b1;
        end
        BYTE_LF: begin
          // cr lf collapses to lf
          cr_next     = 1'b0;
          grp_next[0] = '{data: BYTE_LF, kind: KIND_DATA};
          n_next      = 2'd1;
        end
        BYTE_NUL: begin
          // cr nul gives a bare cr
          if (cr_next) begin
            cr_next     = 1'b0;
            grp_next[0] = '{data: BYTE_CR, kind: KIND_DATA};
          end else begin
            grp_next[0] = '{data: BYTE_NUL, kind: KIND_DATA};
          end
          n_next = 2'd1;
        end
        BYTE_ESC: begin
          if (cr_next) begin
            grp_next[n_next] = '{data: BYTE_CR, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
            cr_next          = 1'b0;
          end
          if (!record_structure) begin
            grp_next[n_next] = '{data: BYTE_ESC, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
          end else if (esc_next) begin
            // esc esc is a literal esc
            grp_next[n_next] = '{data: BYTE_ESC, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
            esc_next         = 1'b0;
          end else begin
            esc_next = 1'b1;
          end
        end
        BYTE_EOR: begin
          // esc eor is end of record, a held cr stays held
          if (esc_next) begin
            grp_next[0] = '{data: BYTE_LF, kind: KIND_DATA};
            esc_next    = 1'b0;
          end else begin
            grp_next[0] = '{data: BYTE_EOR, kind: KIND_DATA};
          end
          n_next = 2'd1;
        end
        BYTE_EOF: begin
          // esc eof ends the transfer with a marker result
          if (esc_next) begin
            grp_next[0] = '{data: BYTE_NUL, kind: KIND_END};
            cr_next     = 1'b0;
            esc_next    = 1'b0;
            fin_next    = 1'b1;
          end else begin
            grp_next[0] = '{data: BYTE_EOF, kind: KIND_DATA};
          end
          n_next = 2'd1;
        end
        default: begin
          // ordinary byte flushes held cr, then held esc, then itself
          if (cr_next) begin
            grp_next[n_next] = '{data: BYTE_CR, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
            cr_next          = 1'b0;
          end
          if (esc_next) begin
            grp_next[n_next] = '{data: BYTE_ESC, kind: KIND_DATA};
            n_next           = n_next + 2'd1;
            esc_next         = 1'b0;
          end
          grp_next[n_next] = '{data: c, kind: KIND_DATA};
          n_next           = n_next + 2'd1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_mode       <= 1'b1;
      record_structure <= 1'b0;
      cr_pending       <= 1'b0;
      esc_pending      <= 1'b0;
      finished         <= 1'b0;
      cnt              <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ASCII_MODE:       ascii_mode       <= cfg_data[0];
          CFG_RECORD_STRUCTURE: record_structure <= cfg_data[0];
          default:              ;
        endcase
      end
      if (s_accept) begin
        cr_pending  <= cr_next;
        esc_pending <= esc_next;
        finished    <= fin_next;
        cnt         <= n_next;
      end else if (m_accept) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // result slots: load a fresh group or shift toward the head
  always_ff @(posedge clk) begin
    if (s_accept) begin
      slot[0] <= grp_next[0];
      slot[1] <= grp_next[1];
      slot[2] <= grp_next[2];
    end else if (m_accept) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

// ===== src/ftpad_checker.sv =====
// port-level checks for the ftp ascii receive decoder, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftpad_checker
  import ftpad_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  `ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
  `ASSERT_NXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")
  `ASSERT_IMP(a_end_marker, clk, rst, m_axis_tvalid && (m_axis_tuser[0] == KIND_END), (m_axis_tdata == BYTE_NUL) && m_axis_tlast, "end marker not zero or not last")
  `ASSERT_IMP(a_idle_ready, clk, rst, !m_axis_tvalid, s_axis_tready, "input blocked with no result pending")

endmodule

bind ftp_ascii_receive_decoder ftpad_checker u_ftpad_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/ftpad_stream_checker.sv =====
// checker for the ftp ascii receive decoder: predicts decoded bytes and compares them
`timescale 1ns / 1ps

module ftpad_stream_checker
  import ftpad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0] s_axis_tuser,   // [0] start_req
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic [0:0] m_axis_tuser,   // [0] kind
  input  logic       m_axis_tlast,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [0:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    result_t res;
    logic    last;
  } decoded_t;

  decoded_t decoded_q[$];
  decoded_t want;
  int       fail_count = 0;
  int       queue_depth = 0;

  // mirrored registers and flags
  logic ascii_mode, record_structure;
  logic cr_held, esc_held, ended;

  assign mismatches  = fail_count;
  assign outstanding = queue_depth;

  function automatic decoded_t as_data(input logic [7:0] b);
    decoded_t d;
    d.res.data = b;
    d.res.kind = KIND_DATA;
    d.last     = 1'b0;
    return d;
  endfunction

  // decode one request and queue the bytes it should produce
  task automatic decode_request(input logic [7:0] c, input logic start);
    decoded_t batch[3];
    int       n;
    n = 0;
    if (start) begin
      cr_held  = 1'b0;
      esc_held = 1'b0;
      ended    = 1'b0;
    end
    if (ended) return;

    if (!ascii_mode) begin
      batch[n] = as_data(c); n++;
    end else if (c == BYTE_CR) begin
      if (esc_held) begin
        batch[n] = as_data(BYTE_ESC); n++;
        esc_held = 1'b0;
      end
      if (cr_held) begin
        batch[n] = as_data(BYTE_CR); n++;
      end
      cr_held = 1'b1;
    end else if (c == BYTE_LF) begin
      cr_held = 1'b0;
      batch[n] = as_data(BYTE_LF); n++;
    end else if (c == BYTE_NUL) begin
      batch[n] = as_data(cr_held ? BYTE_CR : BYTE_NUL); n++;
      cr_held = 1'b0;
    end else if (c == BYTE_ESC) begin
      if (cr_held) begin
        batch[n] = as_data(BYTE_CR); n++;
        cr_held = 1'b0;
      end
      // without record structure a held esc stays held
      if (!record_structure) begin
        batch[n] = as_data(BYTE_ESC); n++;
      end else if (esc_held) begin
        batch[n] = as_data(BYTE_ESC); n++;
        esc_held = 1'b0;
      end else begin
        esc_held = 1'b1;
      end
    end else if (c == BYTE_EOR) begin
      batch[n] = as_data(esc_held ? BYTE_LF : BYTE_EOR); n++;
      esc_held = 1'b0;
    end else if (c == BYTE_EOF) begin
      if (esc_held) begin
        batch[n] = as_data(8'h00);
        batch[n].res.kind = KIND_END;
        n++;
        cr_held  = 1'b0;
        esc_held = 1'b0;
        ended    = 1'b1;
      end else begin
        batch[n] = as_data(BYTE_EOF); n++;
      end
    end else begin
      if (cr_held) begin
        batch[n] = as_data(BYTE_CR); n++;
        cr_held = 1'b0;
      end
      if (esc_held) begin
        batch[n] = as_data(BYTE_ESC); n++;
        esc_held = 1'b0;
      end
      batch[n] = as_data(c); n++;
    end

    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      decoded_q.push_back(batch[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ascii_mode       = 1'b1;
      record_structure = 1'b0;
      cr_held          = 1'b0;
      esc_held         = 1'b0;
      ended            = 1'b0;
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ASCII_MODE) ascii_mode = cfg_data[0];
        else record_structure = cfg_data[0];
      end
      if (s_axis_tvalid && s_axis_tready) decode_request(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %02h kind %0d last %0d",
                   $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.res.data) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.res.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.res.kind) begin
            $display("%0t: kind expected %0d actual %0d",
                     $time, want.res.kind, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
    queue_depth = decoded_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the ftp ascii receive decoder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb;
  import ftpad_pkg::*;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // requests per random phase
  localparam int PHASE_REQS  = 71;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0] s_axis_tuser = 1'b0;    // [0] start_req
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [0:0] m_axis_tuser;           // [0] kind
  logic       m_axis_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = CFG_ASCII_MODE;
  logic [0:0] cfg_data = 1'b0;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  // when set, neither side inserts idle cycles
  logic steady = 1'b0;

  ftp_ascii_receive_decoder dut (.*);

  ftpad_stream_checker chk (.*);

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // downstream stalls about one cycle in five unless steady
  always @(negedge clk) m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);

  // one request on the input stream, with random idle cycles ahead of it
  task automatic send_req(input logic [7:0] b, input logic start);
    while (!steady && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tuser[0] <= start;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending, let every predicted byte drain, then a short pause
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both mode registers, block idle
  task automatic set_mode(input logic ascii, input logic record);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ASCII_MODE;
    cfg_data  <= ascii;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_RECORD_STRUCTURE;
    cfg_data  <= record;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // half control bytes, the rest anything
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 11))
      0:       return BYTE_CR;
      1:       return BYTE_LF;
      2:       return BYTE_NUL;
      3:       return BYTE_ESC;
      4:       return BYTE_EOR;
      5:       return BYTE_EOF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a short well-formed sequence with random content, or a stray byte
  task automatic send_snippet(output int counted);
    logic st;
    int   len;
    counted = 0;
    st = ($urandom_range(0, 49) == 0);
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          send_req(8'($urandom_range(0, 255)), st);
          st = 1'b0;
          counted++;
        end
      end
      3: begin send_req(BYTE_CR, st);  send_req(BYTE_LF, 1'b0);  counted = 2; end
      4: begin send_req(BYTE_CR, st);  send_req(BYTE_NUL, 1'b0); counted = 2; end
      5: begin send_req(BYTE_ESC, st); send_req(BYTE_ESC, 1'b0); counted = 2; end
      6: begin send_req(BYTE_ESC, st); send_req(BYTE_EOR, 1'b0); counted = 2; end
      7: begin send_req(BYTE_CR, st);  send_req(BYTE_CR, 1'b0);  counted = 2; end
      8: begin
        // end of transfer, a few ignored bytes, then a fresh start
        send_req(BYTE_ESC, st);
        send_req(BYTE_EOF, 1'b0);
        len = $urandom_range(0, 2);
        repeat (len) send_req(noise_byte(), 1'b0);
        send_req(noise_byte(), 1'b1);
        counted = 3 + len;
      end
      default: begin send_req(noise_byte(), st); counted = 1; end
    endcase
  endtask

  logic [1:0] phase_mode [6] = '{2'b11, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11};
  int         sent, got;

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // record structure: stream and escape forms
    set_mode(1'b1, 1'b1);
    send_req(8'h41, 1'b1);
    send_req(BYTE_CR, 1'b0);  send_req(BYTE_NUL, 1'b0);   // cr nul gives cr
    send_req(BYTE_CR, 1'b0);  send_req(BYTE_LF, 1'b0);    // cr lf gives lf
    send_req(BYTE_CR, 1'b0);  send_req(BYTE_CR, 1'b0);    // doubled cr
    send_req(8'h7F, 1'b0);
    send_req(BYTE_ESC, 1'b0); send_req(BYTE_ESC, 1'b0);   // esc esc gives esc
    send_req(BYTE_ESC, 1'b0); send_req(BYTE_EOR, 1'b0);   // end of record gives lf
    send_req(BYTE_EOR, 1'b0);                             // bare eor passes
    send_req(BYTE_ESC, 1'b0); send_req(BYTE_CR, 1'b0);    // held esc flushed by cr
    send_req(BYTE_ESC, 1'b0);                             // held cr flushed by esc
    send_req(BYTE_LF, 1'b0);  send_req(BYTE_NUL, 1'b0);   // esc stays held
    send_req(8'h80, 1'b0);
    send_req(BYTE_ESC, 1'b0); send_req(BYTE_EOF, 1'b0);   // end of transfer
    send_req(8'h5A, 1'b0);                                // ignored after end
    send_req(BYTE_CR, 1'b1);  send_req(8'h42, 1'b1);      // start drops held cr
    settle();

    // ascii without record structure: escape codes pass as data
    set_mode(1'b1, 1'b0);
    send_req(BYTE_CR, 1'b0);  send_req(BYTE_ESC, 1'b0);
    send_req(BYTE_EOF, 1'b0);
    settle();

    // image mode, extremes pass unchanged
    set_mode(1'b0, 1'b1);
    send_req(8'h00, 1'b0);    send_req(8'hFF, 1'b0);
    send_req(BYTE_CR, 1'b1);
    settle();

    // random phases; held flags carry across mode changes
    for (int p = 0; p < 6; p++) begin
      set_mode(phase_mode[p][1], phase_mode[p][0]);
      steady <= (p == 3);
      sent = 0;
      while (sent < PHASE_REQS) begin
        send_snippet(got);
        sent += got;
      end
      settle();
    end
    steady <= 1'b0;
    repeat (8) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
